### rtl/core/c3bm_pkg.sv
package c3bm_pkg;

   // frame store geometry
   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // field widths
   localparam int COORD_W = 9;
   localparam int PIXEL_W = 8;
   localparam int SIZE_W  = 10;
   localparam int MODE_W  = 2;
   localparam int COEF_W  = 12;
   localparam int KROW_W  = 3 * COEF_W;
   localparam int ACC_W   = 24;
   localparam int FRAC_W  = 4;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = KROW_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_BORDER_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_TOP    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_MIDDLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_BOTTOM = 3'd5;

   // border modes
   localparam logic [MODE_W-1:0] MODE_NONE     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REFLECT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CIRCULAR = 2'd2;

   // commands carried in tuser
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   // control from the sequencer to the accumulator
   typedef struct packed {
      logic clear;
      logic accumulate;
   } mac_ctrl_type;

endpackage

### rtl/core/c3bm_frame_ram.sv
module c3bm_frame_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 262144,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   // single port, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/c3bm_mac.sv
module c3bm_mac
   import c3bm_pkg::*;
(
   input  logic                     clock,
   input  mac_ctrl_type             ctrl,
   input  logic signed [COEF_W-1:0] coef,
   input  logic [PIXEL_W-1:0]       pixel,
   output logic [PIXEL_W-1:0]       result
);

   localparam int PROD_W = COEF_W + PIXEL_W + 1;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [PROD_W-1:0] product;
   logic signed [ACC_W-FRAC_W-1:0] whole;

   // coefficient times unsigned pixel
   assign product = PROD_W'(coef) * $signed({1'b0, pixel});

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.accumulate) begin
         acc_in = acc_ff + ACC_W'(product);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // drop the fraction and clamp to a byte, negative sums give zero
   assign whole = acc_ff[ACC_W-1:FRAC_W];

   always_comb begin
      if (acc_ff <= 0) begin
         result = '0;
      end else if (whole > (ACC_W - FRAC_W)'(255)) begin
         result = '1;
      end else begin
         result = whole[PIXEL_W-1:0];
      end
   end

endmodule

### rtl/core/conv3x3_border_modes.sv
// 3x3 convolution over one stored 512x512 grayscale frame. A load transfer
// (tuser 0) writes one pixel into the frame store and gives no result. A
// request transfer (tuser 1) gives one filtered pixel: the nine neighbours
// are read one after another through the single port of the frame memory and
// pass the memory read register, the accumulator and the result register
// before a valid result; the next item is accepted only once the sequencer is
// back in idle. A request outside the frame, or on the border in mode none,
// skips the reads and answers with 0.
// The result register lets the next item be accepted while a result waits.
// The frame store has no reset; pixels must be loaded before they are used.
// Kernel coefficients are signed Q7.4; border_mode 0 none, 1 reflect, 2 wrap.
module conv3x3_border_modes
   import c3bm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,  // row[8:0], col[17:9], pixel_in[25:18]
   input  logic                   req_tuser,  // cmd
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,  // pixel_out[7:0]
   // configuration writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_READ   = 2'd1;
   localparam logic [1:0] S_DRAIN  = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   localparam logic [1:0] TAP_LAST = 2'd2;

   // configuration registers
   logic [MODE_W-1:0] border_mode_ff;
   logic [SIZE_W-1:0] frame_width_ff;
   logic [SIZE_W-1:0] frame_height_ff;
   logic [KROW_W-1:0] kernel_ff [3];

   // sequencer
   logic [1:0]         state_ff, state_in;
   logic [1:0]         ri_ff, ri_in;
   logic [1:0]         ci_ff, ci_in;
   logic [COORD_W-1:0] rows_ff [3];
   logic [COORD_W-1:0] cols_ff [3];
   logic               rd_valid_ff;
   logic [1:0]         rd_ri_ff;
   logic [1:0]         rd_ci_ff;
   logic               rsp_valid_ff;
   logic [PIXEL_W-1:0] rsp_data_ff;

   logic [COORD_W-1:0] req_row;
   logic [COORD_W-1:0] req_col;
   logic [PIXEL_W-1:0] req_pixel;
   logic               accept;
   logic               accept_request;
   logic [SIZE_W-1:0]  w_eff;
   logic [SIZE_W-1:0]  h_eff;
   logic               outside;
   logic               on_border;
   logic               zero_result;
   logic               reflect;
   logic               finish_go;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [PIXEL_W-1:0] ram_rdata;

   mac_ctrl_type             mac_ctrl;
   logic [KROW_W-1:0]        coef_row;
   logic signed [COEF_W-1:0] coef;
   logic [PIXEL_W-1:0]       mac_result;

   // neighbour index one step up, with reflect or wrap past the end
   function automatic logic [COORD_W-1:0] map_next(input logic [COORD_W-1:0] p,
                                                   input logic [SIZE_W-1:0] m,
                                                   input logic refl);
      logic [SIZE_W-1:0] last;
      last = m - SIZE_W'(1);
      if ((SIZE_W'(p) + SIZE_W'(1)) >= m) begin
         map_next = refl ? last[COORD_W-1:0] : '0;
      end else begin
         map_next = p + COORD_W'(1);
      end
   endfunction

   // neighbour index one step down, with reflect or wrap before the start
   function automatic logic [COORD_W-1:0] map_prev(input logic [COORD_W-1:0] p,
                                                   input logic [SIZE_W-1:0] m,
                                                   input logic refl);
      logic [SIZE_W-1:0] last;
      last = m - SIZE_W'(1);
      if (p == '0) begin
         map_prev = refl ? '0 : last[COORD_W-1:0];
      end else begin
         map_prev = p - COORD_W'(1);
      end
   endfunction

   assign req_row   = req_tdata[COORD_W-1:0];
   assign req_col   = req_tdata[2*COORD_W-1:COORD_W];
   assign req_pixel = req_tdata[2*COORD_W+PIXEL_W-1:2*COORD_W];

   assign req_tready     = (state_ff == S_IDLE);
   assign accept         = req_tvalid && req_tready;
   assign accept_request = accept && (req_tuser == CMD_REQUEST);

   // frame size in use, zero taken as one and capped at the store size
   always_comb begin
      if (frame_width_ff == '0) begin
         w_eff = SIZE_W'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         w_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         h_eff = SIZE_W'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         h_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height_ff;
      end
   end

   // cases that answer zero without reading the store
   assign outside = (SIZE_W'(req_row) >= h_eff) || (SIZE_W'(req_col) >= w_eff);
   assign on_border = (req_row == '0) || (req_col == '0) ||
                      ((SIZE_W'(req_row) + SIZE_W'(1)) >= h_eff) ||
                      ((SIZE_W'(req_col) + SIZE_W'(1)) >= w_eff);
   assign zero_result = outside ||
                        ((border_mode_ff != MODE_REFLECT) &&
                         (border_mode_ff != MODE_CIRCULAR) && on_border);
   assign reflect = (border_mode_ff != MODE_CIRCULAR);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         border_mode_ff  <= MODE_CIRCULAR;
         frame_width_ff  <= SIZE_W'(MAX_WIDTH);
         frame_height_ff <= SIZE_W'(MAX_HEIGHT);
         kernel_ff[0]    <= '0;
         kernel_ff[1]    <= '0;
         kernel_ff[2]    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BORDER_MODE: begin
               border_mode_ff <= csr_wdata[MODE_W-1:0];
            end
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_wdata[SIZE_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[SIZE_W-1:0];
            end
            CSR_KERNEL_TOP: begin
               kernel_ff[0] <= csr_wdata;
            end
            CSR_KERNEL_MIDDLE: begin
               kernel_ff[1] <= csr_wdata;
            end
            CSR_KERNEL_BOTTOM: begin
               kernel_ff[2] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // neighbour coordinates, kernel row 0 looks one row down, column 0 one right
   always_ff @(posedge clock) begin
      if (accept_request) begin
         rows_ff[0] <= map_next(req_row, h_eff, reflect);
         rows_ff[1] <= req_row;
         rows_ff[2] <= map_prev(req_row, h_eff, reflect);
         cols_ff[0] <= map_next(req_col, w_eff, reflect);
         cols_ff[1] <= req_col;
         cols_ff[2] <= map_prev(req_col, w_eff, reflect);
      end
   end

   assign finish_go = !rsp_valid_ff || rsp_tready;

   // state machine and tap counters
   always_comb begin
      state_in = state_ff;
      ri_in    = ri_ff;
      ci_in    = ci_ff;
      unique case (state_ff)
         S_IDLE: begin
            ri_in = '0;
            ci_in = '0;
            if (accept_request) begin
               state_in = zero_result ? S_FINISH : S_READ;
            end
         end
         S_READ: begin
            if (ci_ff == TAP_LAST) begin
               ci_in = '0;
               ri_in = ri_ff + 2'd1;
               if (ri_ff == TAP_LAST) begin
                  state_in = S_DRAIN;
               end
            end else begin
               ci_in = ci_ff + 2'd1;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (finish_go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ri_ff       <= '0;
         ci_ff       <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ri_ff       <= ri_in;
         ci_ff       <= ci_in;
         rd_valid_ff <= (state_ff == S_READ);
      end
   end

   // tap position that goes with the read data
   always_ff @(posedge clock) begin
      rd_ri_ff <= ri_ff;
      rd_ci_ff <= ci_ff;
   end

   // memory port: loads in idle, neighbour reads while sequencing
   assign ram_we = accept && (req_tuser == CMD_LOAD) &&
                   (32'(req_row) < MAX_HEIGHT) && (32'(req_col) < MAX_WIDTH);

   always_comb begin
      if (state_ff == S_READ) begin
         ram_addr = ADDR_W'(rows_ff[ri_ff]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(cols_ff[ci_ff]);
      end else begin
         ram_addr = ADDR_W'(req_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req_col);
      end
   end

   c3bm_frame_ram #(
      .DATA_W (PIXEL_W),
      .DEPTH  (STORE_DEPTH)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_pixel),
      .rdata (ram_rdata)
   );

   // coefficient for the returning pixel
   assign coef_row = kernel_ff[rd_ri_ff];

   always_comb begin
      case (rd_ci_ff)
         2'd0: coef = coef_row[COEF_W-1:0];
         2'd1: coef = coef_row[2*COEF_W-1:COEF_W];
         2'd2: coef = coef_row[3*COEF_W-1:2*COEF_W];
         default: coef = '0;
      endcase
   end

   assign mac_ctrl.clear      = accept_request;
   assign mac_ctrl.accumulate = rd_valid_ff;

   c3bm_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .coef   (coef),
      .pixel  (ram_rdata),
      .result (mac_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_FINISH) && finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_FINISH) && finish_go) begin
         rsp_data_ff <= mac_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // loads never share the port with neighbour reads
   a_write_only_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE))
      else $error("frame store written outside idle");

   // accumulation follows a read cycle
   a_accumulate_after_read: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> ($past(state_ff) == S_READ))
      else $error("accumulate without a preceding read");

   // a new result appears only out of the finish state
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result raised outside finish");

   // an accepted request leaves idle at once
   a_request_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept_request |=> (state_ff == S_READ || state_ff == S_FINISH))
      else $error("request did not start the sequencer");

endmodule
